/* rtl/pidc_pkg.sv */
`default_nettype none

package pidc_pkg;

	// Fixed-point format of every gain, error and output value.
	localparam int FRAC_BITS = 16;

	// Divider: |error difference| scaled up by the fraction bits.
	localparam int DIV_W = 33 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// A product shifted down by the fraction bits, and the sum of three of them.
	localparam int TERM_W = 64 - FRAC_BITS;
	localparam int ACC_W = TERM_W + 2;

	// Reset values of the configuration registers.
	localparam logic [30:0] OUT_LIMIT_RST = 31'h7FFF_FFFF;
	localparam logic [30:0] DEADBAND_RST = 31'((2 ** FRAC_BITS + 5000) / 10000);

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_OUT_LIMIT = 3'd3,
		REG_REFERENCE = 3'd4,
		REG_DEADBAND  = 3'd5
	} reg_idx_t;

	// Input action codes.
	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

endpackage

`default_nettype wire

/* rtl/pidc_mul.sv */
`default_nettype none

module pidc_mul
	import pidc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [31:0] op_a,
	input  wire logic signed [31:0] op_b,
	output logic signed      [63:0] product_q
);

	// Full 64-bit signed product, registered before anyone uses it.
	always_ff @(posedge clk) begin
		product_q <= op_a * op_b;
	end

endmodule

`default_nettype wire

/* rtl/pidc_div.sv */
`default_nettype none

module pidc_div
	import pidc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [32:0] diff,
	input  wire logic        [30:0] divisor,
	output logic                    busy,
	output logic signed      [31:0] quot_q
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 fin_q;
	logic                 neg_q;
	logic [DIV_W-1:0]     work_q;
	logic [30:0]          rem_q;
	logic [30:0]          div_q;
	logic [32:0]          mag;
	logic [31:0]          trial;
	logic                 take;
	logic                 ovf_pos;
	logic                 ovf_neg;

	assign busy = (cnt_q != '0) || fin_q;

	// Magnitude of the dividend; the sign is applied after the last step.
	assign mag = diff[32] ? 33'(-diff) : 33'(diff);

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, work_q[DIV_W-1]};
	assign take  = trial >= {1'b0, div_q};

	// Saturation of the quotient magnitude to the signed 32-bit range.
	assign ovf_pos = |work_q[DIV_W-1:31];
	assign ovf_neg = (|work_q[DIV_W-1:32]) || (work_q[31] && (|work_q[30:0]));

	// Control: step counter and the final sign and saturation cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {mag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			div_q  <= divisor;
			neg_q  <= diff[32];
		end else if (cnt_q != '0) begin
			work_q <= {work_q[DIV_W-2:0], take};
			rem_q  <= take ? 31'(trial - {1'b0, div_q}) : trial[30:0];
		end
		if (fin_q) begin
			if (neg_q) begin
				quot_q <= ovf_neg ? S32_MIN : 32'(-work_q[31:0]);
			end else begin
				quot_q <= ovf_pos ? S32_MAX : $signed(work_q[31:0]);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/pid_controller_clamped.sv */
`default_nettype none

// Clamped PID controller in signed fixed point with FRAC_BITS fraction bits.
// An update transfer (action 0) forms error = set_value - reference, integrates
// error * time_step when gain_i is positive and |error| exceeds the deadband,
// takes the derivative as the error change divided by time_step, and delivers
// one drive value clamped to +-out_limit; zero_step marks a zero time step, for
// which the derivative is zero. A clear transfer (action 1) zeroes the integral
// and the previous error and gives no result. The divider produces one quotient
// bit per cycle; a zero time step skips the divide. The three gain products and
// the integral product share one registered 32x32 multiplier; the P and I gain
// products overlap the divide. in_stall stays high while an item is in work. A
// finished result waits in an output register, and the block takes the next item
// meanwhile. Configuration is to be written through cfg_wr_en, cfg_index and
// cfg_data only while the block is idle; the user is bound to this, the block
// itself does not enforce it.
// Unknown indexes are ignored.
module pid_controller_clamped
	import pidc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [31:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic signed [31:0] set_value,
	input  wire logic        [30:0] time_step,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [31:0] drive,
	output logic                    zero_step
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULE,
		S_INT,
		S_MULP,
		S_ACCP,
		S_ACCI,
		S_DIVW,
		S_MULD,
		S_ACCD,
		S_DONE
	} state_t;

	state_t state_q;

	logic signed [31:0] gain_p_q;
	logic signed [31:0] gain_i_q;
	logic signed [31:0] gain_d_q;
	logic        [30:0] out_limit_q;
	logic signed [31:0] reference_q;
	logic        [30:0] deadband_q;

	logic signed [31:0] integral_q;
	logic signed [31:0] last_err_q;
	logic signed [31:0] err_q;
	logic        [30:0] dt_q;
	logic               zero_q;
	logic               intg_en_q;
	logic signed [ACC_W-1:0] acc_q;
	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic               zero_step_q;

	logic               in_fire;
	logic signed [32:0] err_wide;
	logic signed [31:0] err_sat;
	logic        [31:0] err_mag;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] product;
	logic signed [TERM_W-1:0] term;
	logic signed [ACC_W-1:0]  term_ext;
	logic signed [TERM_W:0]   isum;
	logic signed [31:0] isum_sat;
	logic               div_start;
	logic               div_busy;
	logic signed [31:0] div_quot;
	logic signed [32:0] err_diff;
	logic signed [ACC_W-1:0] lim_pos;
	logic signed [ACC_W-1:0] lim_neg;
	logic signed [31:0] clamped;
	logic               out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign zero_step = zero_step_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Error of the incoming item, saturated to 32 bits.
	assign err_wide = {set_value[31], set_value} - {reference_q[31], reference_q};
	assign err_sat  = (err_wide[32] != err_wide[31]) ? (err_wide[32] ? S32_MIN : S32_MAX)
	                                                  : err_wide[31:0];
	assign err_mag  = err_q[31] ? 32'(-err_q) : 32'(err_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = gain_p_q;
		mul_b = err_q;
		case (state_q)
			S_MULE: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, dt_q});
			end
			S_ACCP: begin
				mul_a = gain_i_q;
				mul_b = integral_q;
			end
			S_MULD: begin
				mul_a = gain_d_q;
				mul_b = zero_q ? 32'sd0 : div_quot;
			end
			default: begin
				mul_a = gain_p_q;
				mul_b = err_q;
			end
		endcase
	end

	pidc_mul u_mul (
		.clk      (clk),
		.op_a     (mul_a),
		.op_b     (mul_b),
		.product_q(product)
	);

	// Product shifted down by the fraction bits, rounding toward minus infinity.
	assign term     = product[63:FRAC_BITS];
	assign term_ext = {{(ACC_W - TERM_W){term[TERM_W-1]}}, term};

	// Integral update, saturated to 32 bits.
	assign isum     = {{(TERM_W - 31){integral_q[31]}}, integral_q} + {term[TERM_W-1], term};
	assign isum_sat = (isum[TERM_W:31] == '0 || isum[TERM_W:31] == '1) ? isum[31:0]
	                : (isum[TERM_W] ? S32_MIN : S32_MAX);

	// Derivative divide runs alongside the P and I gain products.
	assign err_diff  = {err_q[31], err_q} - {last_err_q[31], last_err_q};
	assign div_start = (state_q == S_INT) && !zero_q;

	pidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (err_diff),
		.divisor(dt_q),
		.busy   (div_busy),
		.quot_q (div_quot)
	);

	// Output clamp to +-out_limit.
	assign lim_pos = $signed({{(ACC_W - 31){1'b0}}, out_limit_q});
	assign lim_neg = -lim_pos;
	always_comb begin
		if (acc_q > lim_pos) begin
			clamped = $signed({1'b0, out_limit_q});
		end else if (acc_q < lim_neg) begin
			clamped = 32'(-$signed({1'b0, out_limit_q}));
		end else begin
			clamped = acc_q[31:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			out_limit_q <= OUT_LIMIT_RST;
			reference_q <= '0;
			deadband_q  <= DEADBAND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIN_P:    gain_p_q    <= cfg_data;
				REG_GAIN_I:    gain_i_q    <= cfg_data;
				REG_GAIN_D:    gain_d_q    <= cfg_data;
				REG_OUT_LIMIT: out_limit_q <= cfg_data[30:0];
				REG_REFERENCE: reference_q <= cfg_data;
				REG_DEADBAND:  deadband_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Item payload captured at the input transfer.
	always_ff @(posedge clk) begin
		if (in_fire && action == ACT_UPDATE) begin
			err_q  <= err_sat;
			dt_q   <= time_step;
			zero_q <= (time_step == '0);
		end
		if (state_q == S_MULE) begin
			intg_en_q <= (gain_i_q > 32'sd0) && (err_mag > {1'b0, deadband_q});
		end
	end

	// Sequencer with controller state, accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			integral_q  <= '0;
			last_err_q  <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			zero_step_q <= 1'b0;
		end else begin
			// In S_DONE the output register is either held or reloaded below.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (action == ACT_CLEAR) begin
							integral_q <= '0;
							last_err_q <= '0;
						end else begin
							state_q <= S_MULE;
						end
					end
				end
				S_MULE: state_q <= S_INT;
				S_INT: begin
					if (intg_en_q) begin
						integral_q <= isum_sat;
					end
					state_q <= S_MULP;
				end
				S_MULP: state_q <= S_ACCP;
				S_ACCP: begin
					acc_q   <= term_ext;
					state_q <= S_ACCI;
				end
				S_ACCI: begin
					acc_q   <= acc_q + term_ext;
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (!div_busy) begin
						state_q <= S_MULD;
					end
				end
				S_MULD: state_q <= S_ACCD;
				S_ACCD: begin
					acc_q   <= acc_q + term_ext;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						drive_q     <= clamped;
						zero_step_q <= zero_q;
						last_err_q  <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* verif/pid_controller_clamped_tb.sv */
`default_nettype none

module pid_controller_clamped_tb;
	import pidc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int BURSTS         = 8;
	localparam int BURST_ITEMS    = 116;

	// Index outside the register map; a write to it must change nothing.
	localparam logic [2:0] IDX_UNUSED = 3'd6;

	typedef struct {
		logic signed [31:0] drive;
		logic               zero_step;
	} drive_result_t;

	// Tracks controller state and configuration, and holds the drive values still due.
	class drive_checker;
		longint gain_p, gain_i, gain_d, limit, level, band;
		longint integral, prev_error;
		drive_result_t awaited[$];
		int mismatches;

		function new();
			gain_p = 0;
			gain_i = 0;
			gain_d = 0;
			limit = longint'(OUT_LIMIT_RST);
			level = 0;
			band = longint'(DEADBAND_RST);
			integral = 0;
			prev_error = 0;
			mismatches = 0;
		endfunction

		static function longint clip32(longint v);
			if (v > longint'(S32_MAX)) return longint'(S32_MAX);
			if (v < longint'(S32_MIN)) return longint'(S32_MIN);
			return v;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_GAIN_P:    gain_p = longint'(signed'(data));
				REG_GAIN_I:    gain_i = longint'(signed'(data));
				REG_GAIN_D:    gain_d = longint'(signed'(data));
				REG_OUT_LIMIT: limit = longint'(data[30:0]);
				REG_REFERENCE: level = longint'(signed'(data));
				REG_DEADBAND:  band = longint'(data[30:0]);
				default: ;
			endcase
		endfunction

		// Advance the controller by one accepted item and queue the drive it yields.
		function void note_item(logic act, logic signed [31:0] sv, logic [30:0] ts);
			longint err, mag, dt, deriv, sum;
			drive_result_t res;
			if (act == ACT_CLEAR) begin
				integral = 0;
				prev_error = 0;
				return;
			end
			dt = longint'(ts);
			err = clip32(longint'(sv) - level);
			mag = (err < 0) ? -err : err;
			// Integration only with a positive integral gain and outside the deadband.
			if (gain_i > 0 && mag > band)
				integral = clip32(integral + ((err * dt) >>> FRAC_BITS));
			// A zero time step drops the derivative term.
			if (dt == 0)
				deriv = 0;
			else
				deriv = clip32(((err - prev_error) <<< FRAC_BITS) / dt);
			sum = ((gain_p * err) >>> FRAC_BITS) + ((gain_i * integral) >>> FRAC_BITS)
				+ ((gain_d * deriv) >>> FRAC_BITS);
			if (sum > limit) sum = limit;
			if (sum < -limit) sum = -limit;
			prev_error = err;
			res.drive = sum[31:0];
			res.zero_step = (dt == 0);
			awaited.push_back(res);
		endfunction

		function void check_drive(logic signed [31:0] d, logic z);
			drive_result_t want;
			if (awaited.size() == 0) begin
				$error("drive: no result expected, actual %0d", d);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (d !== want.drive) begin
				$error("drive: expected %0d, actual %0d", want.drive, d);
				mismatches++;
			end
			if (z !== want.zero_step) begin
				$error("zero_step: expected %0b, actual %0b", want.zero_step, z);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic         [2:0]  cfg_index = '0;
	logic         [31:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                action = ACT_UPDATE;
	logic signed  [31:0] set_value = '0;
	logic         [30:0] time_step = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic signed  [31:0] drive;
	logic                zero_step;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	drive_checker sb = new();

	pid_controller_clamped u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.set_value (set_value),
		.time_step (time_step),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive),
		.zero_step (zero_step)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_drive(drive, zero_step);
	end

	// Ends the run when no transfer happens on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("pid_controller_clamped test failed");
		$finish;
	end

	// Offer one item after a random gap and hold it until the transfer. Entered and left
	// at a falling edge; valid stays high on return so the next item can follow at once.
	task automatic send_item(input logic act, input logic signed [31:0] sv,
		input logic [30:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		set_value <= sv;
		time_step <= ts;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		@(negedge clk);
		sb.note_item(act, sv, ts);
	endtask

	// Stop sending, wait for every outstanding drive value, then let extra cycles pass.
	task automatic drain(input int extra);
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (extra) @(negedge clk);
	endtask

	// Write all six registers, then one unused index with random data.
	task automatic apply_settings(input logic [31:0] kp, ki, kd, lim, lvl, band);
		logic [31:0] vals [6];
		vals = '{kp, ki, kd, lim, lvl, band};
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= vals[i];
			sb.write_reg(reg_idx_t'(i), vals[i]);
			@(negedge clk);
		end
		cfg_index <= IDX_UNUSED;
		cfg_data <= $urandom;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly gains of a few units, sometimes any 32-bit value.
	function automatic logic [31:0] rand_gain();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 32'($urandom_range(1 << 19) - (1 << 18));
	endfunction

	initial begin
		logic               act;
		logic signed [31:0] sv;
		logic        [30:0] ts;
		logic        [31:0] kp, ki, kd, lim, lvl, band;
		int                 pick;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: all gains zero.
		send_item(ACT_UPDATE, S32_MAX, 31'd5);
		send_item(ACT_UPDATE, 32'sd9, '0);
		drain(DRAIN_CYCLES);

		// Unit gains: deadband edge, integral and derivative saturation, clears.
		apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF,
			32'h0, 32'd7);
		send_item(ACT_UPDATE, 32'sd0, '0);
		send_item(ACT_UPDATE, 32'sd7, 31'd1);
		send_item(ACT_UPDATE, 32'sd8, 31'h1_0000);
		send_item(ACT_UPDATE, -32'sd8, 31'h1_0000);
		send_item(ACT_UPDATE, S32_MAX, 31'h7FFF_FFFF);
		send_item(ACT_UPDATE, S32_MAX, 31'h7FFF_FFFF);
		send_item(ACT_UPDATE, S32_MIN, 31'd1);
		send_item(ACT_UPDATE, S32_MAX, 31'd1);
		send_item(ACT_CLEAR, S32_MIN, 31'h7FFF_FFFF);
		send_item(ACT_UPDATE, 32'sh0001_0000, '0);
		send_item(ACT_UPDATE, -32'sh0001_0000, 31'h1_0000);
		send_item(ACT_CLEAR, 32'sd0, '0);
		drain(DRAIN_CYCLES);

		// Extreme gains, zero clamp, error saturating upward, no deadband.
		apply_settings(S32_MIN, S32_MAX, S32_MAX, 32'h8000_0000, S32_MIN, 32'h0);
		send_item(ACT_UPDATE, S32_MAX, 31'h7FFF_FFFF);
		send_item(ACT_UPDATE, S32_MIN, '0);
		drain(DRAIN_CYCLES);

		// Negative integral gain, unit clamp, error saturating downward, widest deadband.
		apply_settings(S32_MAX, 32'hFFFF_FFFF, S32_MIN, 32'h0001_0000, S32_MAX,
			32'hFFFF_FFFF);
		send_item(ACT_UPDATE, S32_MIN, 31'd1);
		send_item(ACT_UPDATE, 32'sd0, 31'd3);
		send_item(ACT_UPDATE, S32_MAX, 31'h7FFF_FFFF);
		send_item(ACT_CLEAR, S32_MAX, 31'd1);
		send_item(ACT_UPDATE, 32'sd0, '0);
		drain(DRAIN_CYCLES);

		// Random settings, each run under one idling phase.
		for (int b = 0; b < BURSTS; b++) begin
			kp = rand_gain();
			ki = rand_gain();
			kd = rand_gain();
			case ($urandom_range(3))
				0: lim = 32'h7FFF_FFFF;
				1: lim = $urandom;
				default: lim = {1'($urandom_range(1)), 31'($urandom_range(1 << 22))};
			endcase
			lvl = $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 21) - (1 << 20));
			case ($urandom_range(3))
				0: band = '0;
				1: band = $urandom_range(64);
				2: band = $urandom_range(1 << 16);
				default: band = $urandom;
			endcase
			apply_settings(kp, ki, kd, lim, lvl, band);

			case (b % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase

			for (int n = 0; n < BURST_ITEMS; n++) begin
				// Halfway through, hold off until the block has delivered everything.
				if (n == BURST_ITEMS / 2)
					drain(1);
				act = ($urandom_range(99) < 6) ? ACT_CLEAR : ACT_UPDATE;
				// Set values mostly near the reference so the error stays in range.
				if ($urandom_range(99) < 70)
					sv = lvl + 32'($urandom_range(1 << 21) - (1 << 20));
				else
					sv = $urandom;
				pick = $urandom_range(99);
				if (pick < 10)
					ts = '0;
				else if (pick < 20)
					ts = 31'($urandom_range(16, 1));
				else if (pick < 80)
					ts = 31'($urandom_range(1 << 18, 1));
				else
					ts = 31'($urandom);
				send_item(act, sv, ts);
			end
			drain(DRAIN_CYCLES);
		end

		if (sb.mismatches == 0)
			$display("pid_controller_clamped test passed");
		else
			$display("pid_controller_clamped test failed");
		$finish;
	end

endmodule

`default_nettype wire
